// ===== design/mpq_pkg.sv =====
// mpq_pkg: shared types and constants for the max priority queue
// word layouts, status and operation codes, entry format
// no dependencies
package mpq_pkg;

   localparam int KEY_W     = 16;
   localparam int TAG_W     = 8;
   localparam int LEVEL_W   = 5;
   localparam int DEPTH_DEF = 16;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } mpq_op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } mpq_status_type;

   typedef struct packed {
      mpq_op_type       operation;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } mpq_req_type;

   typedef struct packed {
      mpq_status_type     status;
      logic [KEY_W-1:0]   out_key;
      logic [TAG_W-1:0]   out_tag;
      logic [LEVEL_W-1:0] level;
   } mpq_rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } mpq_entry_type;

   localparam int ENTRY_W = $bits(mpq_entry_type);

endpackage

// ===== design/mpq_ram.sv =====
// mpq_ram: generic single write port, single read port ram
// read data is registered; no dependencies
module mpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/mpq_cmp.sv =====
// mpq_cmp: shared key comparator that tracks the running maximum
// depends on mpq_pkg for the entry type
module mpq_cmp import mpq_pkg::*; #(
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              cmp_valid,
   input  logic              cmp_first,
   input  logic [ADDR_W-1:0] cmp_idx,
   input  mpq_entry_type     cmp_entry,
   output mpq_entry_type     best_entry,
   output logic [ADDR_W-1:0] best_pos
);

   mpq_entry_type     best_ff;
   logic [ADDR_W-1:0] pos_ff;
   logic              take;

   // strict greater-than keeps the oldest of equal keys
   assign take = cmp_valid && (cmp_first || (cmp_entry.key > best_ff.key));

   always_ff @(posedge clock) begin
      if (take) begin
         best_ff <= cmp_entry;
         pos_ff  <= cmp_idx;
      end
   end

   assign best_entry = best_ff;
   assign best_pos   = pos_ff;

endmodule

// ===== design/max_priority_queue_top.sv =====
// max_priority_queue_top: bounded max priority queue, unsorted storage in arrival order
// depends on mpq_pkg, mpq_ram, mpq_cmp
//
// usage
//   req channel carries one word per operation: push (key, tag) or pop
//   rsp channel returns one word per request: status, popped key/tag, level
//   both channels are valid/ready; a word moves when valid and ready are high
// operation flow
//   push, refused push and refused pop: result written to the output register on accept
//   pop of a queue holding n entries: one ram read per cycle scans all n
//   entries through the shared comparator, the S_PREP state sets up the
//   shift, then one ram copy per cycle closes the gap behind the maximum;
//   the result is registered as the sequencer returns to idle
//   the single ram port pair and the one comparator make this entry by entry
//   one request is in work at a time; req_ready is low during a pop
// stall and reset
//   a result waiting on rsp_ready holds the output register; a new request
//   is taken only once that word leaves (or leaves in the same cycle)
//   reset empties the queue; storage contents are not cleared
module max_priority_queue_top import mpq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  mpq_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output mpq_rsp_type rsp_data
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_PREP  = 4'b0100,
      S_SHIFT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // queue fill and sequencer counters
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rd_ptr_ff, rd_ptr_in;   // next entry to read in scan
   logic [CNT_W-1:0]  dat_idx_ff, dat_idx_in; // entry on ram read data now
   logic [ADDR_W-1:0] wptr_ff, wptr_in;       // shift destination

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   mpq_rsp_type rsp_data_ff, rsp_data_in;

   // ram ports
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   mpq_entry_type     wr_data, rd_data;

   // comparator
   logic              cmp_valid, cmp_first;
   logic [ADDR_W-1:0] best_pos;
   mpq_entry_type     best_entry;

   logic             accept;
   logic             out_free;
   logic [CNT_W-1:0] last_idx;
   mpq_entry_type    push_entry;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign last_idx  = count_ff - CNT_W'(1);

   assign push_entry.key = req_data.key;
   assign push_entry.tag = req_data.tag;

   mpq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mpq_cmp #(
      .ADDR_W (ADDR_W)
   ) u_cmp (
      .clock      (clock),
      .cmp_valid  (cmp_valid),
      .cmp_first  (cmp_first),
      .cmp_idx    (dat_idx_ff[ADDR_W-1:0]),
      .cmp_entry  (rd_data),
      .best_entry (best_entry),
      .best_pos   (best_pos)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      dat_idx_in   = dat_idx_ff;
      wptr_in      = wptr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[ADDR_W-1:0];
      wr_data      = push_entry;
      rd_en        = 1'b0;
      rd_addr      = rd_ptr_ff[ADDR_W-1:0];
      cmp_valid    = 1'b0;
      cmp_first    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_data_in.out_key = '0;
               rsp_data_in.out_tag = '0;
               if (req_data.operation == OP_PUSH) begin
                  rsp_valid_in = 1'b1;
                  if (count_ff == CNT_W'(DEPTH)) begin
                     rsp_data_in.status = ST_FULL;
                     rsp_data_in.level  = LEVEL_W'(count_ff);
                  end else begin
                     wr_en              = 1'b1;
                     count_in           = count_ff + CNT_W'(1);
                     rsp_data_in.status = ST_DONE;
                     rsp_data_in.level  = LEVEL_W'(count_ff + CNT_W'(1));
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in       = 1'b1;
                  rsp_data_in.status = ST_EMPTY;
                  rsp_data_in.level  = '0;
               end else begin
                  // start the scan with entry zero
                  rd_en      = 1'b1;
                  rd_addr    = '0;
                  rd_ptr_in  = CNT_W'(1);
                  dat_idx_in = '0;
                  state_in   = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            cmp_valid  = 1'b1;
            cmp_first  = (dat_idx_ff == '0);
            dat_idx_in = dat_idx_ff + CNT_W'(1);
            if (rd_ptr_ff < count_ff) begin
               rd_en     = 1'b1;
               rd_ptr_in = rd_ptr_ff + CNT_W'(1);
            end
            if (dat_idx_ff == last_idx) begin
               state_in = S_PREP;
            end
         end

         S_PREP: begin
            // maximum is known; fetch the entry just behind it
            rd_en   = 1'b1;
            rd_addr = best_pos + ADDR_W'(1);
            wptr_in = best_pos;
            if (CNT_W'(best_pos) == last_idx) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_SHIFT;
            end
         end

         S_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = wptr_ff;
            wr_data = rd_data;
            rd_en   = 1'b1;
            rd_addr = wptr_ff + ADDR_W'(1) + ADDR_W'(1);
            wptr_in = wptr_ff + ADDR_W'(1);
            if (CNT_W'(wptr_ff) + CNT_W'(1) == last_idx) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // pop completes on the way back to idle
      if (state_ff != S_IDLE && state_in == S_IDLE) begin
         count_in            = last_idx;
         rsp_valid_in        = 1'b1;
         rsp_data_in.status  = ST_DONE;
         rsp_data_in.out_key = best_entry.key;
         rsp_data_in.out_tag = best_entry.tag;
         rsp_data_in.level   = LEVEL_W'(last_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_ptr_ff    <= '0;
         dat_idx_ff   <= '0;
         wptr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_ptr_ff    <= rd_ptr_in;
         dat_idx_ff   <= dat_idx_in;
         wptr_ff      <= wptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/mpq_checker.sv =====
// mpq_checker: port level assertions for the max priority queue, bound to the top
// depends on mpq_pkg and max_priority_queue_top
module mpq_checker import mpq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input mpq_rsp_type rsp_data
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   // no new request while the result register is blocked
   a_no_accept_when_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while result blocked");

   // refused pop reports an empty queue with zero payload
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_EMPTY |->
         rsp_data.out_key == '0 && rsp_data.out_tag == '0 && rsp_data.level == '0)
      else $error("refused pop carries data");

   // refused push only when full
   a_full_push: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL |-> rsp_data.level == LEVEL_W'(DEPTH))
      else $error("push refused below capacity");

   // result register empty after reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind max_priority_queue_top mpq_checker #(.DEPTH(DEPTH)) u_mpq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
